>>> src/rswp_pkg.sv
// ============================================================================
// rswp_pkg: shared types for the rank sort with payload block
// Controller states and the command and status groups between the
// controller and the datapath.
// ============================================================================
package rswp_pkg;

    // Field widths fixed by the item format.
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 24;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the input word and read the top entry
        logic shift;      // move the read entry up one place
        logic place;      // write the held word at the insert position
        logic idx_clr;    // restart the output index
        logic emit_rd;    // read the entry at the output index
        logic emit_next;  // step the output index
        logic count_clr;  // empty the store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // store holds its maximum number of entries
        logic empty;      // store holds no entry
        logic pos_zero;   // insert position is at the bottom
        logic key_gt;     // entry read below the position is greater
        logic held_last;  // held word carries the last mark
        logic emit_last;  // output index points at the final entry
    } t_status;

endpackage

>>> src/rswp_in_if.sv
// ============================================================================
// rswp_in_if: input channel
// Valid/ready channel that carries one unsorted word.
// ============================================================================
interface rswp_in_if;
    logic                          valid;
    logic                          ready;
    logic [rswp_pkg::KEY_W-1:0]     key;
    logic [rswp_pkg::PAYLOAD_W-1:0] payload;
    logic                          last_in;

    modport source (output valid, key, payload, last_in, input ready);
    modport sink   (input valid, key, payload, last_in, output ready);
endinterface

>>> src/rswp_out_if.sv
// ============================================================================
// rswp_out_if: output channel
// Valid/ready channel that carries one sorted word.
// ============================================================================
interface rswp_out_if;
    logic                          valid;
    logic                          ready;
    logic [rswp_pkg::KEY_W-1:0]     sorted_key;
    logic [rswp_pkg::PAYLOAD_W-1:0] sorted_payload;
    logic                          last_out;

    modport source (output valid, sorted_key, sorted_payload, last_out, input ready);
    modport sink   (input valid, sorted_key, sorted_payload, last_out, output ready);
endinterface

>>> src/rswp_dp.sv
// ============================================================================
// rswp_dp: datapath of the rank sort
// Holds the sorted store in a memory, the held input word, the insert
// position, the fill count and the output index.
// ============================================================================
module rswp_dp #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rswp_pkg::t_cmd                i_cmd,
    output rswp_pkg::t_status             o_status,
    input  logic [rswp_pkg::KEY_W-1:0]     i_key,
    input  logic [rswp_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic                          i_last_in,
    output logic [rswp_pkg::KEY_W-1:0]     o_rd_key,
    output logic [rswp_pkg::PAYLOAD_W-1:0] o_rd_payload
);
    import rswp_pkg::*;

    localparam int ENTRY_W = KEY_W + PAYLOAD_W;

    logic [ENTRY_W-1:0]   r_mem [MAX_ITEMS];
    logic [ENTRY_W-1:0]   r_rd;
    logic [KEY_W-1:0]     r_key;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 r_last;
    logic [AW-1:0]        r_pos;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;

    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;

    // Read address: top entry on accept, two below the position while
    // shifting (the entry at position minus one is already in hand).
    always_comb begin
        priority if (i_cmd.accept) begin
            rd_addr = r_count[AW-1:0] - AW'(1);
        end else if (i_cmd.shift) begin
            rd_addr = r_pos - AW'(2);
        end else begin
            rd_addr = r_idx;
        end
    end

    assign rd_en   = i_cmd.accept | i_cmd.shift | i_cmd.emit_rd;
    assign wr_en   = i_cmd.shift | i_cmd.place;
    assign wr_data = i_cmd.shift ? r_rd : {r_key, r_payload};

    // Store memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Held input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= i_key;
            r_payload <= i_payload;
            r_last    <= i_last_in;
        end
    end

    // Insert position, fill count and output index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_pos <= r_count[AW-1:0];
            end else if (i_cmd.shift) begin
                r_pos <= r_pos - AW'(1);
            end
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.emit_next) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Status toward the controller.
    assign o_status.full      = (r_count == CW'(MAX_ITEMS));
    assign o_status.empty     = (r_count == '0);
    assign o_status.pos_zero  = (r_pos == '0);
    assign o_status.key_gt    = (r_rd[ENTRY_W-1:PAYLOAD_W] > r_key);
    assign o_status.held_last = r_last;
    assign o_status.emit_last = ((CW'(r_idx) + CW'(1)) == r_count);

    assign o_rd_key     = r_rd[ENTRY_W-1:PAYLOAD_W];
    assign o_rd_payload = r_rd[PAYLOAD_W-1:0];

endmodule

>>> src/rswp_ctrl.sv
// ============================================================================
// rswp_ctrl: controller of the rank sort
// Sequences accept, insertion shifts and the sorted output of the list.
// ============================================================================
module rswp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rswp_pkg::t_status i_status,
    output rswp_pkg::t_cmd    o_cmd
);
    import rswp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_status.full) begin
                        // A word that finds the store full is dropped.
                        if (i_in_last) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = ST_EMIT_RD;
                        end
                    end else begin
                        o_cmd.accept = 1'b1;
                        n_state      = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                // Greater keys move up; equal keys stay below the new one.
                if (i_status.pos_zero || !i_status.key_gt) begin
                    o_cmd.place = 1'b1;
                    if (i_status.held_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_EMIT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        o_cmd.count_clr = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/rank_sort_with_payload_top.sv
// Insertion: each held key greater than an accepted word's key moves up one
// place; the store memory moves one entry a cycle, and then the word is placed.
// A new word is accepted only after the previous one is placed. The sorted list
// leaves one word at a time: read from the memory, then shown until taken.
// Reset: synchronous, active low; clears the controller, fill count and indexes.
// The store memory is not cleared; entries at or above the fill count are never used.
// ============================================================================
// rank_sort_with_payload_top: stable sorting buffer for key and payload words
// Collects words until one marked last, then emits them in ascending key
// order, equal keys in arrival order. Words that find the store full are dropped.
// ============================================================================
module rank_sort_with_payload_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rswp_in_if.sink           i_in,
    rswp_out_if.source        o_out
);
    import rswp_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_cmd    cmd;
    t_status st;

    // Controller.
    rswp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_in),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (st),
        .o_cmd       (cmd)
    );

    // Datapath.
    rswp_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (st),
        .i_key        (i_in.key),
        .i_payload    (i_in.payload),
        .i_last_in    (i_in.last_in),
        .o_rd_key     (o_out.sorted_key),
        .o_rd_payload (o_out.sorted_payload)
    );

    assign o_out.last_out = st.emit_last;

`ifndef SYNTHESIS
    // A word is never placed into a full store.
    a_place_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.place |-> !st.full)
        else $error("word placed into a full store");

    // A shift never runs below the bottom entry.
    a_shift_above_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> !st.pos_zero)
        else $error("shift below the bottom entry");

    // Input and output sides are never open together.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is shown");

    // Sending the final word of a list empties the store.
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_out) |=> st.empty)
        else $error("store not empty after the final word");
`endif

endmodule

>>> tb/rswp_checker.sv
// ============================================================================
// rswp_checker: sorting predictor and result checker
// Watches both channels of the sorting buffer. Each accepted input word is
// inserted into a model of the store in stable key order. A word marked last
// releases the whole list as expected sorted words. Each accepted output word
// is then compared field by field against the oldest expected word.
// ============================================================================
module rswp_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rswp_in_if   i_in,
    rswp_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import rswp_pkg::*;

    // One stored word of the list.
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_held_word;

    // One sorted word expected on the output.
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_sorted_word;

    t_held_word   held_list[$];
    t_sorted_word sorted_due[$];

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("%0t checker: %s", $time, what);
        o_fail_count++;
    endtask

    // Insert behind all keys that are not greater, so ties keep arrival order.
    // A word that finds the list full is dropped.
    task automatic insert_word(input logic [KEY_W-1:0] key_v,
                               input logic [PAYLOAD_W-1:0] pay_v);
        int         pos;
        t_held_word entry;
        if (held_list.size() < MAX_ITEMS) begin
            entry.key     = key_v;
            entry.payload = pay_v;
            pos = held_list.size();
            while (pos > 0 && held_list[pos-1].key > key_v)
                pos--;
            held_list.insert(pos, entry);
        end
    endtask

    // Release the held list as expected sorted words and empty it.
    task automatic release_list();
        t_sorted_word word;
        foreach (held_list[i]) begin
            word.key     = held_list[i].key;
            word.payload = held_list[i].payload;
            word.last    = (i == held_list.size() - 1);
            sorted_due.push_back(word);
        end
        held_list.delete();
    endtask

    // Outputs are checked before inputs are taken, so an unexpected word
    // cannot be matched against a list released on the same edge.
    always @(posedge i_clk) begin
        t_sorted_word want;
        if (!i_rst_n) begin
            held_list.delete();
            sorted_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (sorted_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word key %h payload %h last %b",
                                              i_out.sorted_key, i_out.sorted_payload,
                                              i_out.last_out));
                end else begin
                    want = sorted_due.pop_front();
                    if (i_out.sorted_key !== want.key)
                        report_mismatch($sformatf("key %h, expected %h",
                                                  i_out.sorted_key, want.key));
                    if (i_out.sorted_payload !== want.payload)
                        report_mismatch($sformatf("payload %h, expected %h (key %h)",
                                                  i_out.sorted_payload, want.payload,
                                                  want.key));
                    if (i_out.last_out !== want.last)
                        report_mismatch($sformatf("last %b, expected %b (key %h)",
                                                  i_out.last_out, want.last, want.key));
                end
            end
            if (i_in.valid && i_in.ready) begin
                insert_word(i_in.key, i_in.payload);
                if (i_in.last_in)
                    release_list();
            end
        end
        o_pending = sorted_due.size();
    end

endmodule

>>> tb/tb_top.sv
// ============================================================================
// tb_top: testbench for the rank sort with payload block
// Sends directed and random lists of key and payload words, some of them
// long enough to overflow the store, under three patterns of sender and
// receiver idling. The checker predicts and compares; this module drives
// the stimulus, guards against a hang and gives the verdict.
// ============================================================================
module tb_top;
    import rswp_pkg::*;

    localparam int MAX_ITEMS      = 64;
    localparam int PHASE_WORDS    = 170;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    // Kinds of key values that one list draws from.
    typedef enum int {
        KEYS_FULL,
        KEYS_TIES,
        KEYS_EDGE,
        KEYS_MIXED
    } t_key_mix;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic recv_ready = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   phase_words;
    int   idle_cycles;
    int   chk_fail_count;
    int   chk_pending;

    rswp_in_if  in_ch();
    rswp_out_if out_ch();

    assign out_ch.ready = recv_ready;

    rank_sort_with_payload_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    rswp_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(chk_fail_count),
        .o_pending   (chk_pending)
    );

    // Clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // Receiver stalls at random with the current idle percentage.
    always @(posedge clk) begin
        if (!rst_n)
            recv_ready <= 1'b0;
        else
            recv_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hang guard: count cycles in which no word moves on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Send one word, idling first at random; returns on the accepting edge.
    task automatic send_word(input logic [KEY_W-1:0] key_v,
                             input logic [PAYLOAD_W-1:0] pay_v,
                             input logic last_v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.key     <= key_v;
        in_ch.payload <= pay_v;
        in_ch.last_in <= last_v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        phase_words++;
    endtask

    // Send a list of random words with the last mark on the final one.
    task automatic send_list(input int len, input t_key_mix mix);
        logic [KEY_W-1:0]     key_v;
        logic [PAYLOAD_W-1:0] pay_v;
        for (int i = 0; i < len; i++) begin
            case (mix)
                KEYS_FULL: key_v = $urandom;
                KEYS_TIES: key_v = $urandom_range(0, 7);
                KEYS_EDGE: begin
                    case ($urandom_range(0, 3))
                        0:       key_v = '0;
                        1:       key_v = '1;
                        2:       key_v = 32'h8000_0000;
                        default: key_v = 32'h7FFF_FFFF;
                    endcase
                end
                default: key_v = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
            endcase
            pay_v = 24'($urandom);
            send_word(key_v, pay_v, i == len - 1);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int len;
        int pick;
        in_ch.valid   <= 1'b0;
        in_ch.key     <= '0;
        in_ch.payload <= '0;
        in_ch.last_in <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            phase_words = 0;
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // Lists of one word at both key extremes.
                send_word('0, '0, 1'b1);
                send_word('1, '1, 1'b1);
                // Extremes and ties: equal keys must leave in arrival order.
                send_word(32'd5,          24'h000001, 1'b0);
                send_word('1,             24'h000002, 1'b0);
                send_word('0,             24'h000003, 1'b0);
                send_word(32'd5,          24'h000004, 1'b0);
                send_word(32'h8000_0000,  24'h800000, 1'b0);
                send_word(32'd5,          24'h000006, 1'b0);
                send_word(32'h7FFF_FFFF,  24'h7FFFFF, 1'b0);
                send_word('0,             '1,         1'b0);
                send_word(32'd1,          24'hA5A5A5, 1'b1);
                // Descending keys force the longest shifts.
                for (int i = 8; i > 0; i--)
                    send_word(32'h1000_0000 * i, 24'(24'h5A5A5A ^ i), i == 1);
                // Ascending keys need no shift at all.
                for (int i = 0; i < 4; i++)
                    send_word(32'hFFFF_FFF0 + i, 24'(24'hFFFFF0 + i), i == 3);
            end

            // Each phase sends a list that overflows the store before its random lists.
            send_list($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6),
                      t_key_mix'($urandom_range(0, 3)));
            while (phase_words < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    len = $urandom_range(1, 12);
                else if (pick < 90)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6);
                send_list(len, t_key_mix'($urandom_range(0, 3)));
            end
        end
        in_ch.valid <= 1'b0;

        // Wait for every sorted word, then let the block settle.
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk_fail_count == 0 && chk_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> rank_sort_with_payload_top.f
src/rswp_pkg.sv
src/rswp_in_if.sv
src/rswp_out_if.sv
src/rswp_dp.sv
src/rswp_ctrl.sv
src/rank_sort_with_payload_top.sv
tb/rswp_checker.sv
tb/tb_top.sv
